>>> sv/brl_pkg.sv
package brl_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int COLOR_BITS         = 8;
    localparam int CFG_DATA_BITS      = 12;
    localparam int CFG_INDEX_BITS     = 1;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    // setup stage -> walker stage
    typedef struct packed {
        logic valid;
        logic start;
        logic steep;
        logic minor_down;
        logic single;
    } setup_ctrl_t;

endpackage

>>> sv/brl_cmd_if.sv
interface brl_cmd_if #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
);
    logic                               valid;
    logic                               ready;
    logic                               opcode;
    logic signed [COORD_BITS-1:0]       start_x;
    logic signed [COORD_BITS-1:0]       start_y;
    logic signed [COORD_BITS-1:0]       end_x;
    logic signed [COORD_BITS-1:0]       end_y;
    logic [brl_pkg::COLOR_BITS-1:0]     pen_color;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, pen_color,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, pen_color,
        output ready
    );
endinterface

>>> sv/brl_pix_if.sv
interface brl_pix_if #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
);
    logic                               valid;
    logic                               ready;
    logic signed [COORD_BITS-1:0]       pixel_x;
    logic signed [COORD_BITS-1:0]       pixel_y;
    logic [brl_pkg::COLOR_BITS-1:0]     pixel_color;
    logic                               visible;
    logic                               last;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, visible, last,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, visible, last,
        output ready
    );
endinterface

>>> sv/brl_setup.sv
module brl_setup #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    brl_cmd_if.sink                            cmd,
    input  logic                               advance,
    output brl_pkg::setup_ctrl_t               ctrl,
    output logic signed [COORD_BITS-1:0]       major_start,
    output logic signed [COORD_BITS-1:0]       major_stop,
    output logic signed [COORD_BITS-1:0]       minor_start,
    output logic [COORD_BITS-1:0]              major_len,
    output logic [COORD_BITS-1:0]              minor_len,
    output logic [brl_pkg::COLOR_BITS-1:0]     color
);

    localparam int DW = COORD_BITS + 1;

    logic signed [DW-1:0]          dx;
    logic signed [DW-1:0]          dy;
    logic signed [DW-1:0]          adx;
    logic signed [DW-1:0]          ady;
    logic signed [DW-1:0]          dmaj;
    logic signed [DW-1:0]          dmin;
    logic signed [DW-1:0]          amaj;
    logic signed [DW-1:0]          amin;
    logic                          steep_c;
    logic                          swap;
    logic                          start_c;
    logic                          minor_down_c;
    logic signed [COORD_BITS-1:0]  maj1;
    logic signed [COORD_BITS-1:0]  maj2;
    logic signed [COORD_BITS-1:0]  min1;
    logic signed [COORD_BITS-1:0]  min2;
    logic                          load;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          start_reg;
    logic                          steep_reg;
    logic                          minor_down_reg;
    logic                          single_reg;
    logic signed [COORD_BITS-1:0]  major_start_reg;
    logic signed [COORD_BITS-1:0]  major_stop_reg;
    logic signed [COORD_BITS-1:0]  minor_start_reg;
    logic [COORD_BITS-1:0]         major_len_reg;
    logic [COORD_BITS-1:0]         minor_len_reg;
    logic [brl_pkg::COLOR_BITS-1:0] color_reg;

    always_comb
    begin
        dx = {cmd.end_x[COORD_BITS-1], cmd.end_x} - {cmd.start_x[COORD_BITS-1], cmd.start_x};
        dy = {cmd.end_y[COORD_BITS-1], cmd.end_y} - {cmd.start_y[COORD_BITS-1], cmd.start_y};
        adx = dx[DW-1] ? -dx : dx;
        ady = dy[DW-1] ? -dy : dy;
        steep_c = ady > adx;

        dmaj = steep_c ? dy : dx;
        dmin = steep_c ? dx : dy;
        amaj = steep_c ? ady : adx;
        amin = steep_c ? adx : ady;
        maj1 = steep_c ? cmd.start_y : cmd.start_x;
        maj2 = steep_c ? cmd.end_y   : cmd.end_x;
        min1 = steep_c ? cmd.start_x : cmd.start_y;
        min2 = steep_c ? cmd.end_x   : cmd.end_y;

        // order endpoints so the major coordinate increases
        swap = dmaj[DW-1];
        // minor moves down unless the ordered minor delta is positive
        minor_down_c = swap ? !dmin[DW-1] : (dmin[DW-1] || (dmin == '0));

        unique case (cmd.opcode)
            brl_pkg::OP_START: start_c = 1'b1;
            brl_pkg::OP_STEP:  start_c = 1'b0;
            default:           start_c = 1'b0;
        endcase
    end

    assign cmd.ready = !s1_valid_reg || advance;
    assign load      = cmd.valid && cmd.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd.ready)
        begin
            s1_valid_next = cmd.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            start_reg       <= start_c;
            steep_reg       <= steep_c;
            minor_down_reg  <= minor_down_c;
            single_reg      <= (amaj == '0);
            major_start_reg <= swap ? maj2 : maj1;
            major_stop_reg  <= swap ? maj1 : maj2;
            minor_start_reg <= swap ? min2 : min1;
            major_len_reg   <= amaj[COORD_BITS-1:0];
            minor_len_reg   <= amin[COORD_BITS-1:0];
            color_reg       <= cmd.pen_color;
        end
    end

    assign ctrl.valid      = s1_valid_reg;
    assign ctrl.start      = start_reg;
    assign ctrl.steep      = steep_reg;
    assign ctrl.minor_down = minor_down_reg;
    assign ctrl.single     = single_reg;
    assign major_start     = major_start_reg;
    assign major_stop      = major_stop_reg;
    assign minor_start     = minor_start_reg;
    assign major_len       = major_len_reg;
    assign minor_len       = minor_len_reg;
    assign color           = color_reg;

endmodule

>>> sv/brl_walker.sv
module brl_walker #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [brl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [brl_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    input  brl_pkg::setup_ctrl_t                  ctrl,
    input  logic signed [COORD_BITS-1:0]          major_start,
    input  logic signed [COORD_BITS-1:0]          major_stop,
    input  logic signed [COORD_BITS-1:0]          minor_start,
    input  logic [COORD_BITS-1:0]                 major_len,
    input  logic [COORD_BITS-1:0]                 minor_len,
    input  logic [brl_pkg::COLOR_BITS-1:0]        color,
    output logic                                  advance,
    brl_pix_if.source                             pix
);

    localparam int EW = COORD_BITS + 4;
    localparam int IW = COORD_BITS + 3;
    localparam int SW = (COORD_BITS > brl_pkg::CFG_DATA_BITS) ?
                        COORD_BITS : brl_pkg::CFG_DATA_BITS;
    localparam logic signed [COORD_BITS-1:0] ONE = {{(COORD_BITS-1){1'b0}}, 1'b1};

    logic [brl_pkg::CFG_DATA_BITS-1:0] screen_width_reg;
    logic [brl_pkg::CFG_DATA_BITS-1:0] screen_height_reg;

    logic                           line_active_reg,   line_active_next;
    logic signed [COORD_BITS-1:0]   major_pos_reg,     major_pos_next;
    logic signed [COORD_BITS-1:0]   major_end_reg,     major_end_next;
    logic signed [COORD_BITS-1:0]   minor_pos_reg,     minor_pos_next;
    logic signed [EW-1:0]           error_acc_reg,     error_acc_next;
    logic signed [IW-1:0]           step_incr_reg,     step_incr_next;
    logic signed [IW-1:0]           straight_incr_reg, straight_incr_next;
    logic                           steep_reg,         steep_next;
    logic                           minor_down_reg,    minor_down_next;
    logic [brl_pkg::COLOR_BITS-1:0] line_color_reg,    line_color_next;
    logic                           out_valid_reg,     out_valid_next;

    logic signed [COORD_BITS-1:0]   pix_x_reg;
    logic signed [COORD_BITS-1:0]   pix_y_reg;
    logic [brl_pkg::COLOR_BITS-1:0] pix_color_reg;
    logic                           visible_reg;
    logic                           last_reg;

    logic                           fire;
    logic                           emit;
    logic                           last_c;
    logic signed [EW-1:0]           da_e;
    logic signed [EW-1:0]           db_e;
    logic signed [EW-1:0]           db2_e;
    logic signed [EW-1:0]           diff2_e;
    logic signed [IW-1:0]           incr_sel;
    logic signed [COORD_BITS-1:0]   major_inc;
    logic signed [COORD_BITS-1:0]   x_c;
    logic signed [COORD_BITS-1:0]   y_c;
    logic [SW-1:0]                  x_ext;
    logic [SW-1:0]                  y_ext;
    logic [SW-1:0]                  w_ext;
    logic [SW-1:0]                  h_ext;
    logic                           visible_c;

    assign advance = !out_valid_reg || pix.ready;
    assign fire    = ctrl.valid && advance;
    assign emit    = fire && (ctrl.start || line_active_reg);

    always_comb
    begin
        da_e    = {4'b0000, major_len};
        db_e    = {4'b0000, minor_len};
        db2_e   = db_e <<< 1;
        diff2_e = (db_e - da_e) <<< 1;
        // error term negative: straight move, else diagonal move
        incr_sel  = error_acc_reg[EW-1] ? straight_incr_reg : step_incr_reg;
        major_inc = major_pos_reg + ONE;

        line_active_next   = line_active_reg;
        major_pos_next     = major_pos_reg;
        major_end_next     = major_end_reg;
        minor_pos_next     = minor_pos_reg;
        error_acc_next     = error_acc_reg;
        step_incr_next     = step_incr_reg;
        straight_incr_next = straight_incr_reg;
        steep_next         = steep_reg;
        minor_down_next    = minor_down_reg;
        line_color_next    = line_color_reg;
        last_c             = 1'b0;

        if (fire && ctrl.start)
        begin
            major_pos_next     = major_start;
            major_end_next     = major_stop;
            minor_pos_next     = minor_start;
            error_acc_next     = db2_e - da_e;
            step_incr_next     = diff2_e[IW-1:0];
            straight_incr_next = db2_e[IW-1:0];
            steep_next         = ctrl.steep;
            minor_down_next    = ctrl.minor_down;
            line_color_next    = color;
            line_active_next   = !ctrl.single;
            last_c             = ctrl.single;
        end
        else if (fire && line_active_reg)
        begin
            major_pos_next = major_inc;
            if (!error_acc_reg[EW-1])
            begin
                minor_pos_next = minor_down_reg ? (minor_pos_reg - ONE) : (minor_pos_reg + ONE);
            end
            error_acc_next   = error_acc_reg + {incr_sel[IW-1], incr_sel};
            last_c           = !(major_inc < major_end_reg);
            line_active_next = !last_c;
        end

        x_c = steep_next ? minor_pos_next : major_pos_next;
        y_c = steep_next ? major_pos_next : minor_pos_next;
        x_ext = SW'($unsigned(x_c));
        y_ext = SW'($unsigned(y_c));
        w_ext = SW'(screen_width_reg);
        h_ext = SW'(screen_height_reg);
        visible_c = !x_c[COORD_BITS-1] && !y_c[COORD_BITS-1] &&
                    (x_ext < w_ext) && (y_ext < h_ext);

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= '0;
            screen_height_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                brl_pkg::REG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                brl_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                default:                    screen_width_reg  <= screen_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_active_reg   <= 1'b0;
            major_pos_reg     <= '0;
            major_end_reg     <= '0;
            minor_pos_reg     <= '0;
            error_acc_reg     <= '0;
            step_incr_reg     <= '0;
            straight_incr_reg <= '0;
            steep_reg         <= 1'b0;
            minor_down_reg    <= 1'b0;
            line_color_reg    <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            line_active_reg   <= line_active_next;
            major_pos_reg     <= major_pos_next;
            major_end_reg     <= major_end_next;
            minor_pos_reg     <= minor_pos_next;
            error_acc_reg     <= error_acc_next;
            step_incr_reg     <= step_incr_next;
            straight_incr_reg <= straight_incr_next;
            steep_reg         <= steep_next;
            minor_down_reg    <= minor_down_next;
            line_color_reg    <= line_color_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_x_reg     <= x_c;
            pix_y_reg     <= y_c;
            pix_color_reg <= line_color_next;
            visible_reg   <= visible_c;
            last_reg      <= last_c;
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = pix_x_reg;
    assign pix.pixel_y     = pix_y_reg;
    assign pix.pixel_color = pix_color_reg;
    assign pix.visible     = visible_reg;
    assign pix.last        = last_reg;

`ifndef SYNTHESIS
    a_active_before_end: assert property (@(posedge clk) disable iff (!rst_n)
        line_active_reg |-> (major_pos_reg < major_end_reg))
        else $error("active line already at or past its end");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_c) |=> !line_active_reg)
        else $error("line still active after its last pixel");

    a_emit_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid_reg)
        else $error("emitted pixel not held in output register");

    a_pending_mid_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> line_active_reg)
        else $error("non-final pixel pending with no active line");
`endif

endmodule

>>> sv/bresenham_line_rasterizer.sv
// An accepted cmd transaction is registered in the setup stage, then its pixel in the
// walker output register on pix. One start or step per cycle unless pix stalls; the
// step path is one error add and one end compare on registered walker state.
// A step with no active line gives no pixel. Output stalls back up through both stages.
// Reset (rst_n low, async) clears the line state, screen size and both valid flags.
module bresenham_line_rasterizer #(
    parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [brl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [brl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    brl_cmd_if.sink                            cmd,
    brl_pix_if.source                          pix
);

    brl_pkg::setup_ctrl_t            ctrl;
    logic                            advance;
    logic signed [COORD_BITS-1:0]    major_start;
    logic signed [COORD_BITS-1:0]    major_stop;
    logic signed [COORD_BITS-1:0]    minor_start;
    logic [COORD_BITS-1:0]           major_len;
    logic [COORD_BITS-1:0]           minor_len;
    logic [brl_pkg::COLOR_BITS-1:0]  color;

    brl_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .advance     (advance),
        .ctrl        (ctrl),
        .major_start (major_start),
        .major_stop  (major_stop),
        .minor_start (minor_start),
        .major_len   (major_len),
        .minor_len   (minor_len),
        .color       (color)
    );

    brl_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ctrl        (ctrl),
        .major_start (major_start),
        .major_stop  (major_stop),
        .minor_start (minor_start),
        .major_len   (major_len),
        .minor_len   (minor_len),
        .color       (color),
        .advance     (advance),
        .pix         (pix)
    );

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import brl_pkg::*;

    localparam int CW           = COORD_BITS_DEFAULT;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int TOTAL_ITEMS  = 1550;
    localparam int DIRECTED     = 25;
    localparam int PHASES       = 7;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic                  opcode;
        coord_t                sx;
        coord_t                sy;
        coord_t                ex;
        coord_t                ey;
        logic [COLOR_BITS-1:0] color;
    } line_cmd_t;

    typedef struct packed {
        coord_t                x;
        coord_t                y;
        logic [COLOR_BITS-1:0] color;
        logic                  visible;
        logic                  last;
    } pixel_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_e;

    class pixel_scoreboard;
        logic [CFG_DATA_BITS-1:0] screen_w = '0;
        logic [CFG_DATA_BITS-1:0] screen_h = '0;
        bit                       walking = 0;
        bit                       steep = 0;
        bit                       minor_down = 0;
        coord_t                   major_pos = '0;
        coord_t                   major_end = '0;
        coord_t                   minor_pos = '0;
        logic signed [15:0]       error_acc = '0;
        logic signed [14:0]       step_incr = '0;
        logic signed [14:0]       straight_incr = '0;
        logic [COLOR_BITS-1:0]    line_color = '0;
        pixel_t                   expected_pixels[$];
        int                       errors = 0;

        function void set_screen(logic [CFG_INDEX_BITS-1:0] idx,
                                 logic [CFG_DATA_BITS-1:0] val);
            if (idx == REG_SCREEN_WIDTH)
                screen_w = val;
            else
                screen_h = val;
        endfunction

        function void plot_pixel(bit is_last);
            pixel_t p;
            coord_t x;
            coord_t y;
            x = steep ? minor_pos : major_pos;
            y = steep ? major_pos : minor_pos;
            p.x       = x;
            p.y       = y;
            p.color   = line_color;
            p.visible = x >= 0 && y >= 0 &&
                        int'(x) < int'(screen_w) && int'(y) < int'(screen_h);
            p.last    = is_last;
            expected_pixels.push_back(p);
        endfunction

        // Rasterize one accepted transaction into the expected pixel stream.
        function void trace_line(line_cmd_t c);
            int x1, y1, x2, y2, adx, ady, a1, b1, a2, b2, t, da, db;
            bit at_end;
            if (c.opcode == OP_START) begin
                x1 = c.sx;
                y1 = c.sy;
                x2 = c.ex;
                y2 = c.ey;
                adx = x2 >= x1 ? x2 - x1 : x1 - x2;
                ady = y2 >= y1 ? y2 - y1 : y1 - y2;
                steep = ady > adx;
                if (steep)
                begin
                    a1 = y1; b1 = x1; a2 = y2; b2 = x2;
                end
                else
                begin
                    a1 = x1; b1 = y1; a2 = x2; b2 = y2;
                end
                if (a1 > a2)
                begin
                    t = a1; a1 = a2; a2 = t;
                    t = b1; b1 = b2; b2 = t;
                end
                minor_down    = !(b2 > b1);
                da            = a2 - a1;
                db            = b2 >= b1 ? b2 - b1 : b1 - b2;
                error_acc     = 16'(2 * db - da);
                step_incr     = 15'(2 * (db - da));
                straight_incr = 15'(2 * db);
                major_pos     = coord_t'(a1);
                major_end     = coord_t'(a2);
                minor_pos     = coord_t'(b1);
                line_color    = c.color;
                walking       = da != 0;
                plot_pixel(da == 0);
            end
            else if (walking)
            begin
                major_pos += 1;
                if (error_acc >= 0)
                begin
                    minor_pos += minor_down ? -1 : 1;
                    error_acc += step_incr;
                end
                else
                begin
                    error_acc += straight_incr;
                end
                at_end = major_pos >= major_end;
                if (at_end)
                    walking = 0;
                plot_pixel(at_end);
            end
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pixel: expected none, actual x=%0d y=%0d",
                         $time, got.x, got.y);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("pixel_x", want.x, got.x);
            compare_field("pixel_y", want.y, got.y);
            compare_field("pixel_color", want.color, got.color);
            compare_field("visible", want.visible, got.visible);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    brl_cmd_if #(.COORD_BITS(CW)) cmd_bus ();
    brl_pix_if #(.COORD_BITS(CW)) pix_bus ();

    bresenham_line_rasterizer #(.COORD_BITS(CW)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_bus),
        .pix       (pix_bus)
    );

    pixel_scoreboard sb = new;
    int items_sent = 0;
    int burst_left = 0;

    always #4 clk = ~clk;

    function automatic int clip_coord(int v);
        if (v < -(1 << (CW - 1)))
            return -(1 << (CW - 1));
        if (v > (1 << (CW - 1)) - 1)
            return (1 << (CW - 1)) - 1;
        return v;
    endfunction

    function automatic int abs_int(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int major_span(int x1, int y1, int x2, int y2);
        int sx, sy;
        sx = abs_int(x2 - x1);
        sy = abs_int(y2 - y1);
        return sx > sy ? sx : sy;
    endfunction

    function automatic int full_coord();
        return int'($urandom_range(0, (1 << CW) - 1)) - (1 << (CW - 1));
    endfunction

    // Mostly near the origin or the screen edge so clipping flips both ways.
    function automatic int pick_base(int screen);
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return int'($urandom_range(0, 80)) - 16;
        if (r < 6)
            return screen + int'($urandom_range(0, 40)) - 20;
        return full_coord();
    endfunction

    task automatic send_item(line_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                cmd_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        cmd_bus.valid     <= 1'b1;
        cmd_bus.opcode    <= c.opcode;
        cmd_bus.start_x   <= c.sx;
        cmd_bus.start_y   <= c.sy;
        cmd_bus.end_x     <= c.ex;
        cmd_bus.end_y     <= c.ey;
        cmd_bus.pen_color <= c.color;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        items_sent++;
    endtask

    // Step transactions carry random junk in the coordinate fields.
    task automatic send_step();
        line_cmd_t c;
        c.opcode = OP_STEP;
        c.sx     = coord_t'($urandom);
        c.sy     = coord_t'($urandom);
        c.ex     = coord_t'($urandom);
        c.ey     = coord_t'($urandom);
        c.color  = COLOR_BITS'($urandom);
        send_item(c);
    endtask

    task automatic draw_line(int x1, int y1, int x2, int y2,
                             logic [COLOR_BITS-1:0] color, int steps);
        line_cmd_t c;
        c.opcode = OP_START;
        c.sx     = coord_t'(clip_coord(x1));
        c.sy     = coord_t'(clip_coord(y1));
        c.ex     = coord_t'(clip_coord(x2));
        c.ey     = coord_t'(clip_coord(y2));
        c.color  = color;
        send_item(c);
        repeat (steps) send_step();
    endtask

    task automatic set_screen(int w, int h);
        cmd_bus.valid <= 1'b0;
        burst_left = 0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SCREEN_WIDTH;
        cfg_data  <= CFG_DATA_BITS'(w);
        sb.set_screen(REG_SCREEN_WIDTH, CFG_DATA_BITS'(w));
        @(posedge clk);
        cfg_index <= REG_SCREEN_HEIGHT;
        cfg_data  <= CFG_DATA_BITS'(h);
        sb.set_screen(REG_SCREEN_HEIGHT, CFG_DATA_BITS'(h));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(int target);
        int kind, x1, y1, x2, y2, len, steps, r;
        while (items_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 95)
            begin
                if (kind < 65)
                begin
                    // short line, mostly run to its end
                    x1 = pick_base(int'(sb.screen_w));
                    y1 = pick_base(int'(sb.screen_h));
                    x2 = x1 + int'($urandom_range(0, 48)) - 24;
                    y2 = y1 + int'($urandom_range(0, 48)) - 24;
                end
                else if (kind < 75)
                begin
                    // horizontal, vertical, diagonal or a single point
                    x1 = pick_base(int'(sb.screen_w));
                    y1 = pick_base(int'(sb.screen_h));
                    len = int'($urandom_range(0, 24)) - 12;
                    r = $urandom_range(0, 3);
                    x2 = (r == 1 || r == 3) ? x1 : x1 + len;
                    y2 = (r == 0 || r == 3) ? y1 : y1 + (r == 2 ? len : -len);
                end
                else if (kind < 88)
                begin
                    // wide endpoints, corners included; usually cut short
                    x1 = ($urandom_range(0, 3) == 0) ? -(1 << (CW - 1)) : full_coord();
                    y1 = ($urandom_range(0, 3) == 0) ? -(1 << (CW - 1)) : full_coord();
                    x2 = ($urandom_range(0, 3) == 0) ? (1 << (CW - 1)) - 1 : full_coord();
                    y2 = ($urandom_range(0, 3) == 0) ? (1 << (CW - 1)) - 1 : full_coord();
                end
                else
                begin
                    x1 = pick_base(int'(sb.screen_w));
                    y1 = pick_base(int'(sb.screen_h));
                    x2 = x1 + int'($urandom_range(0, 400)) - 200;
                    y2 = y1 + int'($urandom_range(0, 400)) - 200;
                end
                x1 = clip_coord(x1);
                y1 = clip_coord(y1);
                x2 = clip_coord(x2);
                y2 = clip_coord(y2);
                len = major_span(x1, y1, x2, y2);
                r = $urandom_range(0, 99);
                if (kind >= 75 && kind < 88)
                    steps = $urandom_range(0, 20);
                else if (r < 70)
                    steps = len;
                else if (r < 85)
                    steps = len + int'($urandom_range(1, 2));
                else
                    steps = $urandom_range(0, len);
                if (steps > len + 2)
                    steps = len + 2;
                draw_line(x1, y1, x2, y2, COLOR_BITS'($urandom), steps);
            end
            else
            begin
                repeat ($urandom_range(1, 3)) send_step();
            end
        end
    endtask

    initial
    begin : stimulus
        int w, h;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= REG_SCREEN_WIDTH;
        cfg_data          <= '0;
        cmd_bus.valid     <= 1'b0;
        cmd_bus.opcode    <= OP_START;
        cmd_bus.start_x   <= '0;
        cmd_bus.start_y   <= '0;
        cmd_bus.end_x     <= '0;
        cmd_bus.end_y     <= '0;
        cmd_bus.pen_color <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-size screen: step with no line, then a single point
        send_step();
        draw_line(0, 0, 0, 0, 8'hA5, 0);

        set_screen(32, 24);
        draw_line(-(1 << (CW - 1)), -(1 << (CW - 1)), (1 << (CW - 1)) - 1,
                  (1 << (CW - 1)) - 1, 8'hFF, 2);
        // restart over an active line; walks up to the top x value, minor going down
        draw_line((1 << (CW - 1)) - 1, -(1 << (CW - 1)), (1 << (CW - 1)) - 8,
                  -(1 << (CW - 1)) + 3, 8'h00, 7);
        draw_line(5, 10, 5, 6, 8'h01, 4);
        draw_line(3, 3, 1, 8, 8'h7E, 5);
        send_step();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin w = 2048; h = 2048; end
                1: begin w = 4095; h = 4095; end
                2: begin w = 0;    h = 2048; end
                3: begin w = 2048; h = 0;    end
                4: begin w = 1;    h = 1;    end
                5: begin w = $urandom_range(0, 4095); h = $urandom_range(0, 4095); end
                default: begin w = $urandom_range(1, 64); h = $urandom_range(1, 64); end
            endcase
            set_screen(w, h);
            run_random(DIRECTED + (ph + 1) * (TOTAL_ITEMS - DIRECTED) / PHASES);
        end

        cmd_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin : pix_sink
        rx_mode_e mode;
        int left, tick;
        mode = RX_OPEN;
        left = 0;
        tick = 0;
        pix_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = rx_mode_e'($urandom_range(0, 3));
                left = $urandom_range(20, 300);
            end
            left--;
            tick++;
            case (mode)
                RX_OPEN:   pix_bus.ready <= 1'b1;
                RX_COIN:   pix_bus.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: pix_bus.ready <= ($urandom_range(0, 3) == 0);
                default:   pix_bus.ready <= (tick % 5) < 3;
            endcase
        end
    end

    // Sees both handshakes in one place so notes always precede checks.
    initial
    begin : monitor
        line_cmd_t c;
        pixel_t p;
        int quiet;
        bit moved;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            moved = 0;
            if (rst_n)
            begin
                if (cmd_bus.valid && cmd_bus.ready)
                begin
                    c.opcode = cmd_bus.opcode;
                    c.sx     = cmd_bus.start_x;
                    c.sy     = cmd_bus.start_y;
                    c.ex     = cmd_bus.end_x;
                    c.ey     = cmd_bus.end_y;
                    c.color  = cmd_bus.pen_color;
                    sb.trace_line(c);
                    moved = 1;
                end
                if (pix_bus.valid && pix_bus.ready)
                begin
                    p.x       = pix_bus.pixel_x;
                    p.y       = pix_bus.pixel_y;
                    p.color   = pix_bus.pixel_color;
                    p.visible = pix_bus.visible;
                    p.last    = pix_bus.last;
                    sb.check_pixel(p);
                    moved = 1;
                end
                quiet = moved ? 0 : quiet + 1;
            end
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

endmodule
